// ----- design/assert_macros.svh -----
// Assertion macros shared by the noise pipeline modules.
// Needs signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle.
`define PVN_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Condition holds in the following cycle.
`define PVN_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- design/pvn_pkg.sv -----
// Shared constants and types of the periodic value noise pipeline.
// No dependencies.
package pvn_pkg;

   localparam int COORD_W     = 24;
   localparam int FRAC_BITS   = 16;
   localparam int INT_W       = COORD_W - FRAC_BITS;
   localparam int MAX_OCTAVES = 8;
   localparam int OCT_W       = 3;
   localparam int CELL_LAT    = 6;

   localparam logic [31:0] HASH_K1   = 32'h9E37_79B9;
   localparam logic [31:0] HASH_K2   = 32'h85EB_CA6B;
   localparam logic [31:0] HASH_K3   = 32'hC2B2_AE35;
   localparam logic [31:0] SEED_STEP = 32'd101;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_SEED     = 3'd0;
   localparam logic [2:0] CSR_PERIOD_X = 3'd1;
   localparam logic [2:0] CSR_PERIOD_Y = 3'd2;
   localparam logic [2:0] CSR_OCTAVES  = 3'd3;

   localparam logic [31:0] SEED_RESET    = 32'd0;
   localparam logic [7:0]  PERIOD_RESET  = 8'd4;
   localparam logic [3:0]  OCTAVES_RESET = 4'd4;

   // Data handed from one octave cell to the next
   typedef struct packed {
      logic [FRAC_BITS-1:0] xfrac;
      logic [FRAC_BITS-1:0] yfrac;
      logic [INT_W-1:0]     xm;
      logic [INT_W-1:0]     xm1;
      logic [INT_W-1:0]     ym;
      logic [INT_W-1:0]     ym1;
      logic [15:0]          sum;
   } pvn_item_type;

endpackage

// ----- design/periodic_value_noise_fbm.sv -----
// Top level of the tileable fractal value noise generator.
// Depends on pvn_pkg, pvn_mod_step, pvn_octave_cell and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_x_coord, req_y_coord (Q8.16)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_noise_value (Q0.16)
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
// One item per cycle sustained while no held result stalls it; the pipeline is 8
// remainder steps for the period wrap, then 8 octave cells of 6 stages each.
// All octave cells are always traversed; octaves past the count add nothing.
// Reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline, so req_stall follows it.
`include "assert_macros.svh"

module periodic_value_noise_fbm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pvn_pkg::COORD_W-1:0] req_x_coord,
   input  logic [pvn_pkg::COORD_W-1:0] req_y_coord,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [15:0]                 rsp_noise_value,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [31:0]                 csr_wdata
);
   import pvn_pkg::*;

   logic [31:0] seed_ff;
   logic [7:0]  period_x_ff, period_y_ff;
   logic [3:0]  octaves_ff;
   logic [7:0]  div_x, div_y;
   logic [3:0]  oct_eff;
   logic        en;

   logic [INT_W-1:0]     rem_x [INT_W+1];
   logic [INT_W-1:0]     num_x [INT_W+1];
   logic [INT_W-1:0]     rem_y [INT_W+1];
   logic [INT_W-1:0]     num_y [INT_W+1];
   logic [FRAC_BITS-1:0] fx_ff [INT_W];
   logic [FRAC_BITS-1:0] fy_ff [INT_W];
   logic [INT_W-1:0]     mvld_ff;

   logic                 cvld [MAX_OCTAVES+1];
   pvn_item_type         citem [MAX_OCTAVES+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= SEED_RESET;
         period_x_ff <= PERIOD_RESET;
         period_y_ff <= PERIOD_RESET;
         octaves_ff  <= OCTAVES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEED:     seed_ff     <= csr_wdata;
            CSR_PERIOD_X: period_x_ff <= csr_wdata[7:0];
            CSR_PERIOD_Y: period_y_ff <= csr_wdata[7:0];
            CSR_OCTAVES:  octaves_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // zero period acts as one; octave count clamped to 1..MAX_OCTAVES
   always_comb begin
      div_x = (period_x_ff == 8'd0) ? 8'd1 : period_x_ff;
      div_y = (period_y_ff == 8'd0) ? 8'd1 : period_y_ff;
      if (octaves_ff == 4'd0) begin
         oct_eff = 4'd1;
      end else if (octaves_ff > 4'(MAX_OCTAVES)) begin
         oct_eff = 4'(MAX_OCTAVES);
      end else begin
         oct_eff = octaves_ff;
      end
   end

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // integer part modulo the base period, one bit per stage
   assign rem_x[0] = '0;
   assign num_x[0] = req_x_coord[COORD_W-1:FRAC_BITS];
   assign rem_y[0] = '0;
   assign num_y[0] = req_y_coord[COORD_W-1:FRAC_BITS];

   for (genvar i = 0; i < INT_W; i++) begin : g_mod
      pvn_mod_step u_mx (
         .clock   (clock),
         .en      (en),
         .rem_in  (rem_x[i]),
         .num_in  (num_x[i]),
         .divisor (div_x),
         .rem_ff  (rem_x[i+1]),
         .num_ff  (num_x[i+1])
      );
      pvn_mod_step u_my (
         .clock   (clock),
         .en      (en),
         .rem_in  (rem_y[i]),
         .num_in  (num_y[i]),
         .divisor (div_y),
         .rem_ff  (rem_y[i+1]),
         .num_ff  (num_y[i+1])
      );
   end

   // fraction bits travel alongside the remainder steps
   always_ff @(posedge clock) begin
      if (en) begin
         fx_ff[0] <= req_x_coord[FRAC_BITS-1:0];
         fy_ff[0] <= req_y_coord[FRAC_BITS-1:0];
         for (int s = 1; s < INT_W; s++) begin
            fx_ff[s] <= fx_ff[s-1];
            fy_ff[s] <= fy_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= '0;
      end else if (en) begin
         mvld_ff <= {mvld_ff[INT_W-2:0], req_valid};
      end
   end

   // seed item for the first octave, with the wrapped next lattice index
   always_comb begin
      citem[0].xfrac = fx_ff[INT_W-1];
      citem[0].yfrac = fy_ff[INT_W-1];
      citem[0].xm    = rem_x[INT_W];
      citem[0].ym    = rem_y[INT_W];
      citem[0].xm1   = (INT_W'(rem_x[INT_W] + 8'd1) == div_x) ? '0
                       : INT_W'(rem_x[INT_W] + 8'd1);
      citem[0].ym1   = (INT_W'(rem_y[INT_W] + 8'd1) == div_y) ? '0
                       : INT_W'(rem_y[INT_W] + 8'd1);
      citem[0].sum   = '0;
      cvld[0]        = mvld_ff[INT_W-1];
   end

   // chain of octave cells
   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      pvn_octave_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .octave    (OCT_W'(o)),
         .active    (4'(o) < oct_eff),
         .seed      (seed_ff),
         .in_valid  (cvld[o]),
         .in_item   (citem[o]),
         .out_valid (cvld[o+1]),
         .out_item  (citem[o+1])
      );
   end

   assign rsp_valid       = cvld[MAX_OCTAVES];
   assign rsp_noise_value = citem[MAX_OCTAVES].sum;

   `PVN_ASSERT_NEXT(a_mod_frozen, rsp_valid && rsp_stall, $stable(mvld_ff))

endmodule

// ----- design/pvn_mod_step.sv -----
// One restoring remainder step: shifts in one dividend bit per stage.
// Depends on pvn_pkg.
module pvn_mod_step (
   input  logic                      clock,
   input  logic                      en,
   input  logic [pvn_pkg::INT_W-1:0] rem_in,
   input  logic [pvn_pkg::INT_W-1:0] num_in,
   input  logic [pvn_pkg::INT_W-1:0] divisor,
   output logic [pvn_pkg::INT_W-1:0] rem_ff,
   output logic [pvn_pkg::INT_W-1:0] num_ff
);
   import pvn_pkg::*;

   logic [INT_W:0]   trial;
   logic [INT_W-1:0] rem_in_next;
   logic [INT_W-1:0] num_in_next;

   // shift in the top dividend bit, subtract divisor when it fits
   always_comb begin
      trial = {rem_in, num_in[INT_W-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_in_next = INT_W'(trial - {1'b0, divisor});
      end else begin
         rem_in_next = INT_W'(trial);
      end
      num_in_next = {num_in[INT_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_next;
         num_ff <= num_in_next;
      end
   end

endmodule

// ----- design/pvn_octave_cell.sv -----
// One octave of the noise sum: corner hashing, smoothstep and bilinear blend.
// Six-stage internal pipeline. Depends on pvn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pvn_octave_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [pvn_pkg::OCT_W-1:0] octave,
   input  logic                      active,
   input  logic [31:0]               seed,
   input  logic                      in_valid,
   input  pvn_pkg::pvn_item_type     in_item,
   output logic                      out_valid,
   output pvn_pkg::pvn_item_type     out_item
);
   import pvn_pkg::*;

   // stage 1 combinational
   logic [7:0]  lo_x, lo_y, lo_mask;
   logic [15:0] tx, ty;
   logic [15:0] x0, x1, y0, y1;
   logic [15:0] ix [4];
   logic [15:0] iy [4];
   logic [31:0] mx_in [4];
   logic [31:0] my_in [4];
   logic [15:0] t2x_in, t2y_in;

   // stage registers
   logic [31:0] mx_ff [4];
   logic [31:0] my_ff [4];
   logic [15:0] t2x_ff, t2y_ff, tx_ff, ty_ff;
   logic [31:0] g_ff [4];
   logic [31:0] g_in [4];
   logic [15:0] sx_ff, sy_ff, sx_in, sy_in;
   logic [31:0] h_ff [4];
   logic [15:0] sx3_ff, sy3_ff, sy4_ff;
   logic [31:0] top_ff, bot_ff, top_in, bot_in;
   logic [15:0] val_ff, val_in;
   logic [31:0] seed_oct;
   logic [31:0] pre_rot;

   logic [CELL_LAT-2:0] pass_vld_ff;
   pvn_item_type        pass_ff [CELL_LAT-1];
   pvn_item_type        out_in;

   // lattice corners: wrap happens on the octave-0 integer part only,
   // the bits that the octave shift brings up never reach the period
   always_comb begin
      lo_x    = 8'((24'(in_item.xfrac) << octave) >> FRAC_BITS);
      lo_y    = 8'((24'(in_item.yfrac) << octave) >> FRAC_BITS);
      lo_mask = 8'((9'd1 << octave) - 9'd1);
      tx      = 16'(in_item.xfrac << octave);
      ty      = 16'(in_item.yfrac << octave);
      x0      = (16'(in_item.xm) << octave) | 16'(lo_x);
      y0      = (16'(in_item.ym) << octave) | 16'(lo_y);
      x1      = (lo_x == lo_mask) ? (16'(in_item.xm1) << octave) : 16'(x0 + 16'd1);
      y1      = (lo_y == lo_mask) ? (16'(in_item.ym1) << octave) : 16'(y0 + 16'd1);
      ix[0] = x0; ix[1] = x1; ix[2] = x0; ix[3] = x1;
      iy[0] = y0; iy[1] = y0; iy[2] = y1; iy[3] = y1;
      for (int c = 0; c < 4; c++) begin
         mx_in[c] = 32'({16'd0, ix[c]} * HASH_K1);
         my_in[c] = 32'({16'd0, iy[c]} * HASH_K2);
      end
      t2x_in = 16'((32'(tx) * 32'(tx)) >> 16);
      t2y_in = 16'((32'(ty) * 32'(ty)) >> 16);
   end

   // stage 2: seed add, rotate, second lattice term; smoothstep product
   always_comb begin
      seed_oct = seed + 32'(octave) * SEED_STEP;
      pre_rot  = '0;
      for (int c = 0; c < 4; c++) begin
         pre_rot = seed_oct + mx_ff[c];
         g_in[c] = {pre_rot[18:0], pre_rot[31:19]} + my_ff[c];
      end
      sx_in = 16'((36'(t2x_ff) * (36'd196608 - 36'({tx_ff, 1'b0}))) >> 16);
      sy_in = 16'((36'(t2y_ff) * (36'd196608 - 36'({ty_ff, 1'b0}))) >> 16);
   end

   // stage 4 and 5: blend along x, then along y
   always_comb begin
      top_in = 32'(48'(h_ff[0][31:16]) * (48'd65536 - 48'(sx3_ff))
                  + 48'(h_ff[1][31:16]) * 48'(sx3_ff));
      bot_in = 32'(48'(h_ff[2][31:16]) * (48'd65536 - 48'(sx3_ff))
                  + 48'(h_ff[3][31:16]) * 48'(sx3_ff));
      val_in = 16'((50'(top_ff) * (50'd65536 - 50'(sy4_ff))
                  + 50'(bot_ff) * 50'(sy4_ff)) >> 32);
   end

   // stage 6: weighted accumulate; shift count needs a fourth bit for octave 7
   always_comb begin
      out_in = pass_ff[CELL_LAT-2];
      if (active) begin
         out_in.sum = pass_ff[CELL_LAT-2].sum + 16'(val_ff >> (4'(octave) + 4'd1));
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            mx_ff[c] <= mx_in[c];
            my_ff[c] <= my_in[c];
            g_ff[c]  <= g_in[c];
            h_ff[c]  <= 32'(g_ff[c] * HASH_K3);
         end
         t2x_ff  <= t2x_in;
         t2y_ff  <= t2y_in;
         tx_ff   <= tx;
         ty_ff   <= ty;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         sx3_ff  <= sx_ff;
         sy3_ff  <= sy_ff;
         sy4_ff  <= sy3_ff;
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         val_ff  <= val_in;
         pass_ff[0] <= in_item;
         for (int s = 1; s < CELL_LAT-1; s++) begin
            pass_ff[s] <= pass_ff[s-1];
         end
         out_item <= out_in;
      end
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_vld_ff <= '0;
         out_valid   <= 1'b0;
      end else if (en) begin
         pass_vld_ff <= {pass_vld_ff[CELL_LAT-3:0], in_valid};
         out_valid   <= pass_vld_ff[CELL_LAT-2];
      end
   end

   `PVN_ASSERT_NEXT(a_sum_no_wrap, en && pass_vld_ff[CELL_LAT-2],
      out_item.sum >= $past(pass_ff[CELL_LAT-2].sum))
   `PVN_ASSERT_NEXT(a_idle_octave_keeps_sum, en && pass_vld_ff[CELL_LAT-2] && !active,
      out_item.sum == $past(pass_ff[CELL_LAT-2].sum))
   `PVN_ASSERT_NEXT(a_frozen_when_held, !en, $stable(pass_vld_ff) && $stable(out_valid))

endmodule

// ----- tb/tb_periodic_value_noise_fbm.sv -----
// Self-checking testbench for periodic_value_noise_fbm: drives coordinate pairs
// with random idling, predicts each fractal noise sample and compares in order.
// Depends on pvn_pkg and the periodic_value_noise_fbm RTL.
`default_nettype none

// Expected noise samples and the register image they are computed from
class noise_scoreboard;
   logic [31:0] seed;
   logic [7:0]  per_x;
   logic [7:0]  per_y;
   logic [3:0]  octaves;
   logic [15:0] pending_noise[$];
   int          errors;

   function new();
      seed    = pvn_pkg::SEED_RESET;
      per_x   = pvn_pkg::PERIOD_RESET;
      per_y   = pvn_pkg::PERIOD_RESET;
      octaves = pvn_pkg::OCTAVES_RESET;
      errors  = 0;
   endfunction

   // Register write as the block sees it; unknown indexes change nothing
   function void set_reg(logic [2:0] idx, logic [31:0] wdata);
      case (idx)
         pvn_pkg::CSR_SEED:     seed    = wdata;
         pvn_pkg::CSR_PERIOD_X: per_x   = wdata[7:0];
         pvn_pkg::CSR_PERIOD_Y: per_y   = wdata[7:0];
         pvn_pkg::CSR_OCTAVES:  octaves = wdata[3:0];
         default: ;
      endcase
   endfunction

   function logic [15:0] corner_hash(logic [31:0] ix, logic [31:0] iy, logic [31:0] s);
      logic [31:0] h;
      h = s + ix * pvn_pkg::HASH_K1;
      h = {h[18:0], h[31:19]};
      h = h + iy * pvn_pkg::HASH_K2;
      h = h * pvn_pkg::HASH_K3;
      h = h ^ (h >> 16);
      return h[31:16];
   endfunction

   function logic [63:0] smooth(logic [63:0] t);
      logic [63:0] t2;
      t2 = (t * t) >> 16;
      return (t2 * (64'd196608 - 2 * t)) >> 16;
   endfunction

   // One octave of bilinear value noise on a wrapped lattice
   function logic [63:0] octave_noise(logic [23:0] xc, logic [23:0] yc, int o,
                                      logic [31:0] s);
      logic [63:0] xs, ys, px, py, xi, yi, sx, sy, a, b, c, d, top, bot;
      logic [31:0] x0, x1, y0, y1;
      xs = 64'(xc) << o;
      ys = 64'(yc) << o;
      px = 64'((per_x == 0) ? 8'd1 : per_x) << o;
      py = 64'((per_y == 0) ? 8'd1 : per_y) << o;
      xi = xs >> 16;
      yi = ys >> 16;
      x0 = 32'(xi % px);
      x1 = 32'((xi + 1) % px);
      y0 = 32'(yi % py);
      y1 = 32'((yi + 1) % py);
      a  = 64'(corner_hash(x0, y0, s));
      b  = 64'(corner_hash(x1, y0, s));
      c  = 64'(corner_hash(x0, y1, s));
      d  = 64'(corner_hash(x1, y1, s));
      sx = smooth(xs & 64'hFFFF);
      sy = smooth(ys & 64'hFFFF);
      top = a * (64'd65536 - sx) + b * sx;
      bot = c * (64'd65536 - sx) + d * sx;
      return (top * (64'd65536 - sy) + bot * sy) >> 32;
   endfunction

   // Accepted coordinate pair: queue its expected noise sample
   function void note_coord(logic [23:0] xc, logic [23:0] yc);
      int          n;
      logic [63:0] sum;
      n   = (octaves == 0) ? 1 : (octaves > pvn_pkg::MAX_OCTAVES) ?
            pvn_pkg::MAX_OCTAVES : int'(octaves);
      sum = 0;
      for (int o = 0; o < n; o++)
         sum += octave_noise(xc, yc, o, seed + 32'(o) * pvn_pkg::SEED_STEP) >> (o + 1);
      pending_noise.push_back(sum[15:0]);
   endfunction

   function void report(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
   endfunction

   // Accepted result against the oldest expectation
   function void check_noise(logic [15:0] got);
      logic [15:0] want;
      if (pending_noise.size() == 0) begin
         report($sformatf("unexpected noise_value %h", got));
         return;
      end
      want = pending_noise.pop_front();
      if (got !== want)
         report($sformatf("noise_value %h, expected %h", got, want));
   endfunction
endclass

module tb_periodic_value_noise_fbm;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int         STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_x_coord = '0;
   logic [23:0] req_y_coord = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_noise_value;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   bit              quiet = 1'b0;
   int              idle_cycles = 0;
   noise_scoreboard sb = new();

   periodic_value_noise_fbm uut (.*);

   always #5 clock = ~clock;

   // Result side: check every transfer
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_noise(rsp_noise_value);

   // Result side: stall in random bursts unless quiet
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("periodic_value_noise_fbm: mismatch");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] wdata);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      sb.set_reg(idx, wdata);
   endtask

   task automatic set_config(logic [31:0] seed, logic [31:0] px, logic [31:0] py,
                             logic [31:0] oct);
      write_reg(pvn_pkg::CSR_SEED, seed);
      write_reg(pvn_pkg::CSR_PERIOD_X, px);
      write_reg(pvn_pkg::CSR_PERIOD_Y, py);
      write_reg(pvn_pkg::CSR_OCTAVES, oct);
      write_reg(CSR_UNUSED, $urandom);
      csr_we <= 1'b0;
   endtask

   // One coordinate transfer, with an optional idle burst in front
   task automatic send_coord(logic [23:0] xc, logic [23:0] yc);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= xc;
      req_y_coord <= yc;
      do @(posedge clock); while (req_stall);
      sb.note_coord(xc, yc);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 3))
         0:       return {$urandom_range(0, 3) == 0 ? 8'hFF : 8'(0), 16'($urandom)};
         1:       return {8'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         // sender may hold off once, halfway through, until the pipeline has emptied
         if (i == count / 2 && $urandom_range(0, 1)) drain();
         send_coord(rand_coord(), rand_coord());
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes at reset settings, then special register cases
      send_coord(24'h000000, 24'h000000);
      send_coord(24'hFFFFFF, 24'hFFFFFF);
      send_coord(24'h000000, 24'hFFFFFF);
      send_coord(24'hFFFFFF, 24'h000000);
      send_coord(24'h00FFFF, 24'h010000);
      send_coord(24'h038000, 24'h03FFFF);
      send_coord(24'h040000, 24'h7F8000);
      send_coord(24'hAAAAAA, 24'h555555);
      drain();
      // zero periods act as one, zero octave count acts as one
      set_config(32'hFFFF_FF00, 32'hFFFF_FF00, 32'h0000_0100, 32'hFFFF_FFF0);
      send_coord(24'h000000, 24'h000000);
      send_coord(24'hFFFFFF, 24'hFFFFFF);
      send_coord(24'h12C000, 24'h3F4000);
      drain();
      // octave count above the maximum, widest periods
      set_config(32'hFFFF_FFFF, 32'd255, 32'd255, 32'd15);
      send_coord(24'hFFFFFF, 24'h000000);
      send_coord(24'hFE8000, 24'hFEFFFF);
      send_coord(24'h7FFFFF, 24'h800000);
      drain();
      set_config(32'd0, 32'd1, 32'd1, 32'd9);
      send_coord(24'h018000, 24'h008000);
      send_coord(24'hFFFFFF, 24'hFFFFFF);
      drain();

      // Random phases over a range of settings
      set_config($urandom, 32'd4, 32'd4, 32'd8);
      random_phase(100);
      set_config($urandom, 32'd255, 32'd1, 32'd1);
      random_phase(100);
      set_config(32'd0, 32'd1, 32'd255, 32'd8);
      random_phase(100);
      set_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
      random_phase(80);
      for (int p = 0; p < 3; p++) begin
         set_config($urandom, $urandom, $urandom, $urandom);
         random_phase(100);
      end
      // last part without idling on either side
      quiet = 1'b1;
      set_config($urandom, $urandom_range(1, 255), $urandom_range(1, 255), 32'd8);
      random_phase(120);

      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending_noise.size() == 0)
         $display("periodic_value_noise_fbm: match");
      else
         $display("periodic_value_noise_fbm: mismatch");
      $finish;
   end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/pvn_pkg.sv
design/pvn_mod_step.sv
design/pvn_octave_cell.sv
design/periodic_value_noise_fbm.sv
tb/tb_periodic_value_noise_fbm.sv
